### rtl/wwkm_pkg.sv
// shared constants, request codes, cell control bundle and byte helpers
package wwkm_pkg;

  localparam int NUM_WORDS    = 8;
  localparam int MAX_WORD_LEN = 32;
  localparam int HIST_DEPTH   = MAX_WORD_LEN + 1;

  localparam int SLOT_W = $clog2(NUM_WORDS);
  localparam int POS_W  = $clog2(MAX_WORD_LEN);
  localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
  localparam int CNT_W  = $clog2(HIST_DEPTH + 1);
  localparam int MODE_W = 2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CASE_OFS = CH_LO_A - CH_UP_A;

  typedef enum logic [MODE_W-1:0] {
    MODE_BODY    = 2'd0,
    MODE_KW_BYTE = 2'd1,
    MODE_KW_LEN  = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic [7:0]       feed;
    logic             step;
    logic             clear;
    logic             flush;
    logic             kw_we;
    logic             len_we;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  position;
    logic [LEN_W-1:0]  word_length;
    logic [7:0]       wr_byte;
  } cell_ctl_t;

  function automatic logic is_ident_char(logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           (c >= CH_LO_A && c <= CH_LO_Z) || (c == CH_UNDER);
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      return c + CASE_OFS;
    end
    return c;
  endfunction

endpackage

### rtl/wwkm_cell.sv
// one keyword byte position: stored bytes, length marks, prefix-match bits, history byte
module wwkm_cell
  import wwkm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [POS_W-1:0]     cell_idx,
  input  cell_ctl_t            ctl,
  input  logic [NUM_WORDS-1:0] d_in,
  output logic [NUM_WORDS-1:0] d_out,
  input  logic [7:0]           hist_in,
  output logic [7:0]           hist_out,
  output logic                 hit,
  output logic                 hit_nxt
);

  logic [7:0]           kw_r [NUM_WORDS];
  logic [NUM_WORDS-1:0] mask_r;
  logic [NUM_WORDS-1:0] d_r;
  logic [NUM_WORDS-1:0] d_calc;
  logic [NUM_WORDS-1:0] d_nxt;
  logic [7:0]           hist_r;
  logic [LEN_W-1:0]     len_here;

  assign len_here = LEN_W'(cell_idx) + LEN_W'(1);

  // prefix of length cell_idx+1 still matching after this byte
  always_comb begin
    for (int s = 0; s < NUM_WORDS; s++) begin
      d_calc[s] = !ctl.clear && d_in[s] &&
                  (fold_case(ctl.feed) == fold_case(kw_r[s]));
    end
    if (ctl.flush) begin
      d_nxt = '0;
    end else if (ctl.step) begin
      d_nxt = d_calc;
    end else begin
      d_nxt = d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r    <= '0;
      mask_r <= '0;
    end else begin
      d_r <= d_nxt;
      if (ctl.len_we) begin
        mask_r[ctl.slot] <= (ctl.word_length == len_here);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.kw_we && ctl.position == cell_idx) begin
      kw_r[ctl.slot] <= ctl.wr_byte;
    end
    if (ctl.step) begin
      hist_r <= hist_in;
    end
  end

  assign d_out    = d_r;
  assign hist_out = hist_r;
  assign hit      = |(d_r & mask_r);
  assign hit_nxt  = |(d_calc & mask_r);

endmodule

### rtl/whole_word_keyword_matcher.sv
// whole-word case-insensitive keyword matcher: sequencer, cell chain and result register
// the answer for a body is registered: out_valid rises in the cycle after its last byte is accepted
// throughput: one request per cycle of any mode, unless rebuilding or a result is held back
// a keyword byte written while a body is under way starts a rebuild of the
// prefix-match bits (one history byte per cycle round the history ring), not ready meanwhile
// reset clears lengths, match bits, byte count, sticky flag and result valid;
// keyword bytes and history bytes are not reset
module whole_word_keyword_matcher
  import wwkm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [POS_W-1:0]  in_position,
  input  logic [LEN_W-1:0]  in_word_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_matched
);

  // sequencer state
  logic             rp_busy_r, rp_busy_nxt;
  logic [CNT_W-1:0] rp_k_r, rp_k_nxt;
  logic [CNT_W-1:0] bs_r, bs_nxt;
  logic             match_flag_r, match_flag_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_matched_r, out_matched_nxt;
  logic [7:0]       h32_r;

  // request decode
  logic      accept;
  logic      is_body, is_kw_byte, is_kw_len;
  logic      slot_ok, pos_ok;
  logic      flush;
  logic      start_ok;
  logic      check_prev, check_end;
  logic      hit_any, hit_nxt_any;
  cell_ctl_t ctl;

  // cell chain wiring
  logic [NUM_WORDS-1:0] d_chain    [MAX_WORD_LEN+1];
  logic [7:0]           hist_chain [MAX_WORD_LEN+1];
  logic [MAX_WORD_LEN-1:0] hit_vec, hit_nxt_vec;

  // the result register parts the two sides; a rebuild holds off new requests
  assign in_ready = !rp_busy_r && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  assign slot_ok = (32'(in_slot) < NUM_WORDS);
  assign pos_ok  = (32'(in_position) < MAX_WORD_LEN);

  always_comb begin
    is_body    = 1'b0;
    is_kw_byte = 1'b0;
    is_kw_len  = 1'b0;
    unique case (mode_t'(in_mode))
      MODE_BODY:    is_body    = accept;
      MODE_KW_BYTE: is_kw_byte = accept && slot_ok && pos_ok;
      MODE_KW_LEN:  is_kw_len  = accept && slot_ok;
      default:      ;
    endcase
  end

  assign flush = is_body && in_last;

  // start edge: body start, or the byte before is not a word byte; during a rebuild the
  // byte before is the one just rotated into the head of the history
  always_comb begin
    if (rp_busy_r) begin
      start_ok = (bs_r == rp_k_r + CNT_W'(1)) || !is_ident_char(hist_chain[1]);
    end else begin
      start_ok = (bs_r == '0) || !is_ident_char(hist_chain[1]);
    end
  end

  always_comb begin
    ctl.feed        = rp_busy_r ? h32_r : in_data_byte;
    ctl.step        = is_body || rp_busy_r;
    // history slots older than the body hold no body bytes; the oldest slot only
    // serves as the byte before the longest keyword
    ctl.clear       = rp_busy_r && ((rp_k_r >= bs_r) ||
                                    (rp_k_r == CNT_W'(HIST_DEPTH - 1)));
    ctl.flush       = flush;
    ctl.kw_we       = is_kw_byte;
    ctl.len_we      = is_kw_len;
    ctl.slot        = in_slot;
    ctl.position    = in_position;
    ctl.word_length = in_word_length;
    ctl.wr_byte     = in_data_byte;
  end

  // head of the chain: prefix of length zero matches wherever a word may start
  assign d_chain[0]    = {NUM_WORDS{start_ok}};
  assign hist_chain[0] = ctl.feed;

  for (genvar j = 0; j < MAX_WORD_LEN; j++) begin : g_cell
    wwkm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (POS_W'(j)),
      .ctl      (ctl),
      .d_in     (d_chain[j]),
      .d_out    (d_chain[j+1]),
      .hist_in  (hist_chain[j]),
      .hist_out (hist_chain[j+1]),
      .hit      (hit_vec[j]),
      .hit_nxt  (hit_nxt_vec[j])
    );
  end

  assign hit_any     = |hit_vec;
  assign hit_nxt_any = |hit_nxt_vec;

  // a non-word byte closes a keyword ending at the byte before; the body end closes one
  // ending at the last byte
  assign check_prev = is_body && (bs_r != '0) && !is_ident_char(in_data_byte) && hit_any;
  assign check_end  = flush && hit_nxt_any;

  always_comb begin
    bs_nxt          = bs_r;
    match_flag_nxt  = match_flag_r;
    out_valid_nxt   = out_valid_r;
    out_matched_nxt = out_matched_r;
    rp_busy_nxt     = rp_busy_r;
    rp_k_nxt        = rp_k_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (flush) begin
      bs_nxt          = '0;
      match_flag_nxt  = 1'b0;
      out_valid_nxt   = 1'b1;
      out_matched_nxt = match_flag_r || check_prev || check_end;
    end else if (is_body) begin
      match_flag_nxt = match_flag_r || check_prev;
      if (bs_r != CNT_W'(HIST_DEPTH)) begin
        bs_nxt = bs_r + CNT_W'(1);
      end
    end

    // new keyword byte mid-body: replay the history through the chain
    if (rp_busy_r) begin
      rp_k_nxt = rp_k_r - CNT_W'(1);
      if (rp_k_r == '0) begin
        rp_busy_nxt = 1'b0;
      end
    end else if (is_kw_byte && bs_r != '0) begin
      rp_busy_nxt = 1'b1;
      rp_k_nxt    = CNT_W'(HIST_DEPTH - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r          <= '0;
      match_flag_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      rp_busy_r     <= 1'b0;
      rp_k_r        <= '0;
    end else begin
      bs_r          <= bs_nxt;
      match_flag_r  <= match_flag_nxt;
      out_valid_r   <= out_valid_nxt;
      rp_busy_r     <= rp_busy_nxt;
      rp_k_r        <= rp_k_nxt;
    end
  end

  // payload: result value and the oldest history byte closing the ring
  always_ff @(posedge clk) begin
    out_matched_r <= out_matched_nxt;
    if (ctl.step) begin
      h32_r <= hist_chain[MAX_WORD_LEN];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

  // a result appears only for the last byte of a body
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(flush))
    else $error("result raised without a last body request");

  // byte count saturates one past the longest keyword
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bs_r <= CNT_W'(HIST_DEPTH))
    else $error("body byte count out of range");

  // a rebuild leaves the body position untouched
  a_replay_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    rp_busy_r |=> bs_r == $past(bs_r))
    else $error("body byte count moved during rebuild");

  // a rebuild only starts inside a body
  a_replay_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rp_busy_r) |-> $past(bs_r) != '0)
    else $error("rebuild started with no body bytes");

  // end of body clears the per-body state
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    flush |=> (bs_r == '0) && !match_flag_r && (d_chain[1] == '0))
    else $error("per-body state not cleared after last byte");

endmodule

### test/whole_word_keyword_matcher_test.sv
// self-checking bench for the whole-word keyword matcher: table-driven requests, then random text bodies
`timescale 1ns / 100ps

module whole_word_keyword_matcher_test
  import wwkm_pkg::*;
;

  localparam int ITEM_TARGET  = 1950;
  localparam int IDLE_LIMIT   = 1000;  // cycles without any handshake before giving up
  localparam int DRAIN_CYCLES = 8;     // answer comes in the cycle after the last body byte
  localparam int REPORT_LIMIT = 10;
  localparam int TABLE_ROWS   = 24;

  typedef logic [7:0]        octet_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef struct packed {
    mode_t  mode;
    octet_t data;
    logic   last;
    slot_t  slot;
    pos_t   pos;
    len_t   wlen;
  } request_t;

  // one line of the directed table; fixed rows carry the verdict typed in by hand
  typedef struct packed {
    mode_t  mode;
    octet_t data;
    logic   last;
    slot_t  slot;
    pos_t   pos;
    len_t   wlen;
    logic   fixed;
    logic   want;
  } table_row_t;

  logic   clk            = 1'b0;
  logic   rst_n          = 1'b0;
  logic   in_valid       = 1'b0;
  logic   in_ready;
  logic [MODE_W-1:0] in_mode = '0;
  octet_t in_data_byte   = '0;
  logic   in_last        = 1'b0;
  slot_t  in_slot        = '0;
  pos_t   in_position    = '0;
  len_t   in_word_length = '0;
  logic   out_valid;
  logic   out_ready      = 1'b0;
  logic   out_matched;

  whole_word_keyword_matcher dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_data_byte  (in_data_byte),
    .in_last       (in_last),
    .in_slot       (in_slot),
    .in_position   (in_position),
    .in_word_length(in_word_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_matched   (out_matched)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // behavioural copy of the matcher state
  // ---------------------------------------------------------------------------
  octet_t kw_text [NUM_WORDS][MAX_WORD_LEN];  // every entry is written before any body
  len_t   kw_len  [NUM_WORDS] = '{default: '0};
  octet_t recent  [HIST_DEPTH] = '{default: '0};  // recent[0] is the newest body byte
  int     body_count = 0;                          // saturates at HIST_DEPTH
  bit     sticky_hit = 1'b0;

  logic   verdicts_due [$];  // match verdicts still owed by the block, oldest first
  octet_t body_text    [$];  // text body being streamed
  int     items_done   = 0;
  int     failures     = 0;
  int     verdict_index = 0;
  bit     calm         = 1'b0;  // when set neither side idles

  function automatic bit is_word_char(octet_t c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || (c == "_");
  endfunction

  function automatic octet_t lower_case(octet_t c);
    return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
  endfunction

  // does any keyword end at the newest history byte, given count bytes seen so far;
  // the trailing word boundary is the caller's business
  function automatic bit keyword_ends_here(int count);
    int  len;
    bit  same;
    for (int s = 0; s < NUM_WORDS; s++) begin
      len = kw_len[s];
      if (len == 0 || len > MAX_WORD_LEN || len > count) continue;
      // leading boundary: either the body starts here or a non-word byte precedes
      if (count != len && is_word_char(recent[len])) continue;
      same = 1'b1;
      for (int i = 0; i < len; i++) begin
        if (lower_case(kw_text[s][i]) != lower_case(recent[len-1-i])) same = 1'b0;
      end
      if (same) return 1'b1;
    end
    return 1'b0;
  endfunction

  // advance the copied state by one accepted request and say whether it yields a verdict
  function automatic void scan_request(input request_t r, output bit yields,
                                       output bit verdict);
    yields  = 1'b0;
    verdict = 1'b0;
    case (r.mode)
      MODE_KW_BYTE: kw_text[r.slot][r.pos] = r.data;
      MODE_KW_LEN:  kw_len[r.slot] = r.wlen;
      MODE_BODY: begin
        // a non-word byte closes a keyword that ended on the previous byte
        if (body_count > 0 && !is_word_char(r.data) && keyword_ends_here(body_count))
          sticky_hit = 1'b1;
        for (int i = HIST_DEPTH - 1; i > 0; i--) recent[i] = recent[i-1];
        recent[0] = r.data;
        if (body_count < HIST_DEPTH) body_count++;
        if (r.last) begin
          // the end of the body closes a keyword ending on this byte
          if (keyword_ends_here(body_count)) sticky_hit = 1'b1;
          yields     = 1'b1;
          verdict    = sticky_hit;
          sticky_hit = 1'b0;
          body_count = 0;
          for (int i = 0; i < HIST_DEPTH; i++) recent[i] = '0;
        end
      end
      default: ;  // unused mode is dropped by the block
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  task automatic issue_request(input request_t r, input bit fixed, input bit want);
    int gap;
    bit yields;
    bit verdict;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= r.mode;
    in_data_byte   <= r.data;
    in_last        <= r.last;
    in_slot        <= r.slot;
    in_position    <= r.pos;
    in_word_length <= r.wlen;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scan_request(r, yields, verdict);
    if (yields) verdicts_due.push_back(fixed ? want : verdict);
    if (r.mode != MODE_UNUSED) items_done++;
  endtask

  // fields that the mode does not use still carry random bits
  function automatic request_t scrambled_request(mode_t mode);
    request_t r;
    r.mode = mode;
    r.data = octet_t'($urandom_range(0, 255));
    r.last = 1'($urandom_range(0, 1));
    r.slot = slot_t'($urandom_range(0, NUM_WORDS - 1));
    r.pos  = pos_t'($urandom_range(0, MAX_WORD_LEN - 1));
    r.wlen = len_t'($urandom_range(0, 63));
    return r;
  endfunction

  function automatic octet_t word_char();
    int k;
    k = $urandom_range(0, 62);
    if (k < 10) return octet_t'(8'h30 + k);
    if (k < 36) return octet_t'(8'h41 + k - 10);
    if (k < 62) return octet_t'(8'h61 + k - 36);
    return "_";
  endfunction

  function automatic octet_t separator_char();
    octet_t c;
    if ($urandom_range(0, 1) == 0) return " ";
    do c = octet_t'($urandom_range(0, 255)); while (is_word_char(c));
    return c;
  endfunction

  function automatic octet_t flip_case(octet_t c);
    if (((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) && $urandom_range(0, 1) == 1)
      return c ^ 8'h20;
    return c;
  endfunction

  // rewrite one slot: mostly short keywords, now and then long, empty or over-long
  task automatic program_slot(input slot_t s);
    request_t r;
    int       len;
    int       pick;
    pick = $urandom_range(0, 19);
    if (pick < 14)       len = $urandom_range(1, 6);
    else if (pick < 17)  len = $urandom_range(7, MAX_WORD_LEN);
    else if (pick == 17) len = 0;
    else if (pick == 18) len = $urandom_range(MAX_WORD_LEN + 1, 63);
    else                 len = MAX_WORD_LEN;
    for (int p = 0; p < len && p < MAX_WORD_LEN; p++) begin
      r      = scrambled_request(MODE_KW_BYTE);
      r.slot = s;
      r.pos  = pos_t'(p);
      r.data = ($urandom_range(0, 11) == 0) ? separator_char() : word_char();
      issue_request(r, 1'b0, 1'b0);
    end
    r      = scrambled_request(MODE_KW_LEN);
    r.slot = s;
    r.wlen = len_t'(len);
    issue_request(r, 1'b0, 1'b0);
  endtask

  // build a body out of keywords (case scrambled), near misses, plain words and separators
  task automatic compose_body();
    int tokens;
    int kind;
    int s;
    bit front;
    body_text.delete();
    if ($urandom_range(0, 9) == 0) begin
      // raw noise body
      repeat ($urandom_range(1, 40)) body_text.push_back(octet_t'($urandom_range(0, 255)));
      return;
    end
    tokens = $urandom_range(1, 6);
    repeat (tokens) begin
      kind = $urandom_range(0, 9);
      s    = $urandom_range(0, NUM_WORDS - 1);
      if (kind <= 4 && kw_len[s] >= 1 && kw_len[s] <= MAX_WORD_LEN) begin
        // kind 4 glues a word byte onto one end so the boundary test must reject it
        front = 1'($urandom_range(0, 1));
        if (kind == 4 && front) body_text.push_back(word_char());
        for (int i = 0; i < kw_len[s]; i++) body_text.push_back(flip_case(kw_text[s][i]));
        if (kind == 4 && !front) body_text.push_back(word_char());
      end else if (kind <= 6) begin
        repeat ($urandom_range(1, 5)) body_text.push_back(word_char());
      end else begin
        repeat ($urandom_range(1, 2)) body_text.push_back(separator_char());
      end
    end
  endtask

  // stream the body, now and then slipping a table write or an unused-mode request in between
  task automatic stream_body();
    request_t r;
    for (int i = 0; i < body_text.size(); i++) begin
      if ($urandom_range(0, 39) == 0)
        issue_request(scrambled_request(mode_t'($urandom_range(1, 3))), 1'b0, 1'b0);
      r      = scrambled_request(MODE_BODY);
      r.data = body_text[i];
      r.last = (i == body_text.size() - 1);
      issue_request(r, 1'b0, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // verdict sink and checker
  // ---------------------------------------------------------------------------
  task automatic check_verdict(input logic got);
    logic want;
    verdict_index++;
    if (verdicts_due.size() == 0) begin
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("verdict %0d: got %b with nothing outstanding", verdict_index, got);
    end else begin
      want = verdicts_due.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("verdict %0d: expected matched=%b, got %b", verdict_index, want, got);
      end
    end
  endtask

  initial begin : verdict_sink
    int stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && rst_n)) @(posedge clk);
      check_verdict(out_matched);
    end
  end

  // gives up once neither channel has moved for a long while
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    table_row_t rows [TABLE_ROWS];
    request_t   r;

    rows = '{
      // every slot empty after reset, low extremes
      '{MODE_BODY,    8'h00, 1'b1, 3'd0, 5'd0,  6'd0,  1'b1, 1'b0},
      // high extremes on every field
      '{MODE_BODY,    8'hff, 1'b1, 3'd7, 5'd31, 6'd63, 1'b1, 1'b0},
      // keyword "Ab" in slot 0
      '{MODE_KW_BYTE, "A",   1'b0, 3'd0, 5'd0,  6'd0,  1'b0, 1'b0},
      '{MODE_KW_BYTE, "b",   1'b1, 3'd0, 5'd1,  6'd63, 1'b0, 1'b0},
      '{MODE_KW_LEN,  8'hff, 1'b0, 3'd0, 5'd31, 6'd2,  1'b0, 1'b0},
      // whole body equals the keyword, other case
      '{MODE_BODY,    "a",   1'b0, 3'd0, 5'd0,  6'd0,  1'b0, 1'b0},
      '{MODE_BODY,    "B",   1'b1, 3'd0, 5'd0,  6'd0,  1'b0, 1'b0},
      // word byte in front spoils it
      '{MODE_BODY,    "_",   1'b0, 3'd0, 5'd0,  6'd0,  1'b0, 1'b0},
      '{MODE_BODY,    "a",   1'b0, 3'd0, 5'd0,  6'd0,  1'b0, 1'b0},
      '{MODE_BODY,    "b",   1'b1, 3'd0, 5'd0,  6'd0,  1'b0, 1'b0},
      // keyword closed by a non-word byte mid-body
      '{MODE_BODY,    "a",   1'b0, 3'd0, 5'd0,  6'd0,  1'b0, 1'b0},
      '{MODE_BODY,    "B",   1'b0, 3'd0, 5'd0,  6'd0,  1'b0, 1'b0},
      '{MODE_BODY,    " ",   1'b0, 3'd0, 5'd0,  6'd0,  1'b0, 1'b0},
      '{MODE_BODY,    "z",   1'b1, 3'd0, 5'd0,  6'd0,  1'b0, 1'b0},
      // body shorter than the keyword
      '{MODE_BODY,    "a",   1'b1, 3'd0, 5'd0,  6'd0,  1'b0, 1'b0},
      // unused mode, no verdict
      '{MODE_UNUSED,  8'hff, 1'b1, 3'd7, 5'd31, 6'd63, 1'b0, 1'b0},
      // slot 0 emptied, slot 7 longer than any keyword can be
      '{MODE_KW_LEN,  8'h00, 1'b0, 3'd0, 5'd0,  6'd0,  1'b0, 1'b0},
      '{MODE_KW_LEN,  8'h00, 1'b0, 3'd7, 5'd0,  6'd63, 1'b0, 1'b0},
      '{MODE_BODY,    "a",   1'b0, 3'd0, 5'd0,  6'd0,  1'b0, 1'b0},
      '{MODE_BODY,    "b",   1'b1, 3'd0, 5'd0,  6'd0,  1'b0, 1'b0},
      // single-byte keyword written while a body is under way
      '{MODE_BODY,    "-",   1'b0, 3'd0, 5'd0,  6'd0,  1'b0, 1'b0},
      '{MODE_KW_BYTE, "9",   1'b0, 3'd6, 5'd0,  6'd0,  1'b0, 1'b0},
      '{MODE_KW_LEN,  8'h00, 1'b0, 3'd6, 5'd0,  6'd1,  1'b0, 1'b0},
      '{MODE_BODY,    "9",   1'b1, 3'd0, 5'd0,  6'd0,  1'b0, 1'b0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole keyword store so no comparison ever touches an unwritten byte
    for (int s = 0; s < NUM_WORDS; s++) begin
      for (int p = 0; p < MAX_WORD_LEN; p++) begin
        r      = scrambled_request(MODE_KW_BYTE);
        r.slot = slot_t'(s);
        r.pos  = pos_t'(p);
        r.data = word_char();
        issue_request(r, 1'b0, 1'b0);
      end
    end

    // directed table
    foreach (rows[k]) begin
      r.mode = rows[k].mode;
      r.data = rows[k].data;
      r.last = rows[k].last;
      r.slot = rows[k].slot;
      r.pos  = rows[k].pos;
      r.wlen = rows[k].wlen;
      issue_request(r, rows[k].fixed, rows[k].want);
    end

    // random rounds: reprogram a few slots, then stream several bodies
    while (items_done < ITEM_TARGET) begin
      calm = ($urandom_range(0, 5) == 0);
      repeat ($urandom_range(0, 2)) program_slot(slot_t'($urandom_range(0, NUM_WORDS - 1)));
      repeat ($urandom_range(1, 4)) begin
        compose_body();
        stream_body();
      end
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
